FILE: hw/rtl/itoa_pkg.sv
// Shared types, constants and helper functions for the radix integer to ASCII core.
`timescale 1ns / 1ps

package itoa_pkg;

  // Field widths of the request and result channels and of one digit.
  localparam int VALUE_W    = 32;
  localparam int RADIX_W    = 2;
  localparam int MIN_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;

  // Default maximum field width.
  localparam int MAX_WIDTH_DEF = 48;

  // A 32-bit magnitude never has more than 32 digits (binary of 2^31).
  localparam int MAX_DIGITS  = 32;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);

  // Reciprocal of ten: floor(m * RECIP_10 / 2^35) equals m / 10 for any 32-bit m.
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;

  // Radix codes.
  typedef enum logic [RADIX_W-1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  // One classified conversion job, passed from the front end to the back end.
  typedef struct packed {
    logic [VALUE_W-1:0] magnitude;
    logic               neg;
    radix_e             radix;
    logic [MIN_W-1:0]   min_digits;
  } job_t;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } back_state_e;

  // Digit to upper-case ASCII glyph.
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      glyph = ZERO_CHAR + ext;
    end else begin
      glyph = 8'h37 + ext;
    end
  endfunction

endpackage

FILE: hw/rtl/itoa_in_if.sv
// Request channel: one integer with its radix choice and minimum width.
`timescale 1ns / 1ps

interface itoa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [itoa_pkg::VALUE_W-1:0]  value;
  logic        [itoa_pkg::RADIX_W-1:0]  radix_select;
  logic        [itoa_pkg::MIN_W-1:0]    min_digits;

  modport source (output valid, value, radix_select, min_digits, input ready);
  modport sink   (input valid, value, radix_select, min_digits, output ready);
endinterface

FILE: hw/rtl/itoa_out_if.sv
// Result channel: one ASCII character with its end-of-number flag.
`timescale 1ns / 1ps

interface itoa_out_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::CHAR_W-1:0]   text_char;
  logic                          last_char;

  modport source (output valid, text_char, last_char, input ready);
  modport sink   (input valid, text_char, last_char, output ready);
endinterface

FILE: hw/rtl/itoa_front.sv
// Front end: accepts requests, takes sign and magnitude, and holds the job for the queue.
`timescale 1ns / 1ps

module itoa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [itoa_pkg::VALUE_W-1:0]  req_value_i,
  input  logic [itoa_pkg::RADIX_W-1:0]  req_radix_i,
  input  logic [itoa_pkg::MIN_W-1:0]    req_min_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output itoa_pkg::job_t                job_o
);
  import itoa_pkg::*;

  logic valid_q, valid_d;
  job_t job_q, job_d;
  logic accept;

  // The holding register frees up when its job moves into the queue.
  assign req_ready_o = !valid_q || job_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  // Classify the request: sign flag and unsigned magnitude (2^31 for the most negative value).
  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    if (accept) begin
      valid_d          = 1'b1;
      job_d.neg        = req_value_i[VALUE_W-1];
      job_d.magnitude  = req_value_i[VALUE_W-1] ? (VALUE_W'(0) - req_value_i) : req_value_i;
      job_d.radix      = radix_e'(req_radix_i);
      job_d.min_digits = req_min_i;
    end else if (job_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

FILE: hw/rtl/itoa_fifo.sv
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps

module itoa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  itoa_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output itoa_pkg::job_t pop_job_o
);
  import itoa_pkg::*;

  localparam int Depth = 2;

  job_t             entry_q [Depth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'(Depth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: hw/rtl/itoa_back.sv
// Back end: peels digits off the magnitude into a digit store, then emits the padded text.
`timescale 1ns / 1ps

module itoa_back #(
  parameter int MAX_WIDTH = itoa_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  itoa_pkg::job_t               job_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [itoa_pkg::CHAR_W-1:0]  text_char_o,
  output logic                         last_char_o
);
  import itoa_pkg::*;

  // Width of the character position counter; holds MAX_WIDTH itself.
  localparam int CW = $clog2(MAX_WIDTH + 1);

  back_state_e           state_q, state_d;
  logic [VALUE_W-1:0]    mag_q, mag_d;
  logic                  neg_q, neg_d;
  radix_e                radix_q, radix_d;
  logic [MIN_W-1:0]      min_q, min_d;
  logic [NDIG_W-1:0]     ndig_q, ndig_d;
  logic [2*VALUE_W-1:0]  prod_q, prod_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic                  first_q, first_d;
  logic [DIGIT_W-1:0]    store_q [MAX_DIGITS];
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [DIGIT_W-1:0]    conv_digit;
  logic [VALUE_W-1:0]    conv_next;
  logic [VALUE_W-RECIP_SHIFT+VALUE_W-1:0] quot;
  logic [VALUE_W-1:0]    rem_full;
  logic                  store_we;
  logic [NDIG_W-1:0]     nd_next;
  logic [CW-1:0]         natural_len;
  logic [CW-1:0]         min_sat;
  logic [CW-1:0]         field_width;
  logic                  can_load;
  logic [CHAR_W-1:0]     emit_char;

  assign job_ready_o = (state_q == S_IDLE);
  assign can_load    = !out_valid_q || out_ready_i;

  // One digit step: shift and mask for power-of-two radices, reciprocal product for ten.
  always_comb begin
    quot     = prod_q[2*VALUE_W-1:RECIP_SHIFT];
    rem_full = mag_q - {quot, 3'b000} - {2'b00, quot, 1'b0};
    if (state_q == S_DIV) begin
      conv_digit = rem_full[DIGIT_W-1:0];
      conv_next  = {{(VALUE_W-$bits(quot)){1'b0}}, quot};
    end else begin
      case (radix_q)
        RADIX_BIN: begin
          conv_digit = {3'b000, mag_q[0]};
          conv_next  = mag_q >> 1;
        end
        RADIX_OCT: begin
          conv_digit = {1'b0, mag_q[2:0]};
          conv_next  = mag_q >> 3;
        end
        default: begin
          conv_digit = mag_q[3:0];
          conv_next  = mag_q >> 4;
        end
      endcase
    end
  end

  // Field width: the larger of the saturated minimum and the natural length with sign.
  always_comb begin
    nd_next     = ndig_q + NDIG_W'(1);
    natural_len = CW'(nd_next) + CW'(neg_q);
    min_sat     = (CW'(min_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(min_q);
    field_width = (min_sat > natural_len) ? min_sat : natural_len;
  end

  // Character at the current position: sign, stored digit, or leading zero.
  always_comb begin
    if (first_q && neg_q) begin
      emit_char = MINUS_CHAR;
    end else if (pos_q < CW'(ndig_q)) begin
      emit_char = glyph(store_q[pos_q[DIGIT_IDX_W-1:0]]);
    end else begin
      emit_char = ZERO_CHAR;
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    radix_d     = radix_q;
    min_d       = min_q;
    ndig_d      = ndig_q;
    prod_d      = prod_q;
    pos_d       = pos_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    store_we    = 1'b0;

    // A waiting character leaves when the sink takes it.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          mag_d   = job_i.magnitude;
          neg_d   = job_i.neg;
          radix_d = job_i.radix;
          min_d   = job_i.min_digits;
          ndig_d  = '0;
          state_d = (job_i.radix == RADIX_DEC) ? S_MUL : S_SHIFT;
        end
      end
      S_MUL: begin
        prod_d  = mag_q * RECIP_10;
        state_d = S_DIV;
      end
      S_SHIFT, S_DIV: begin
        store_we = 1'b1;
        mag_d    = conv_next;
        ndig_d   = nd_next;
        if (conv_next == '0) begin
          pos_d   = field_width - CW'(1);
          first_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = (state_q == S_DIV) ? S_MUL : S_SHIFT;
        end
      end
      S_EMIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_char_d  = emit_char;
          out_last_d  = (pos_q == '0);
          first_d     = 1'b0;
          pos_d       = pos_q - CW'(1);
          if (pos_q == '0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    radix_q    <= radix_d;
    min_q      <= min_d;
    ndig_q     <= ndig_d;
    prod_q     <= prod_d;
    pos_q      <= pos_d;
    first_q    <= first_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // Digit store, least significant digit at index zero.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[ndig_q[DIGIT_IDX_W-1:0]] <= conv_digit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = out_char_q;
  assign last_char_o = out_last_q;

endmodule

FILE: hw/rtl/radix_integer_to_ascii_core.sv
// Top level of the radix integer to ASCII core: front end, job queue and back end.
//
//   Channel   Dir   Handshake      Payload
//   req_i     in    valid/ready    value, radix_select, min_digits
//   chr_o     out   valid/ready    text_char, last_char
//
// Each number leaves the queue into the back end, which peels off its digits by shift and mask
// for binary, octal and hexadecimal or by reciprocal multiply, then remainder, for decimal,
// then emits the padded text one character at a time.
// The back end converts one number at a time; the front end and the two-entry queue take
// further requests meanwhile. Reset is asynchronous and active low and clears all control
// state. A stalled result sink holds the back end in place.
`timescale 1ns / 1ps

module radix_integer_to_ascii_core #(
  parameter int MAX_WIDTH = itoa_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_in_if.sink     req_i,
  itoa_out_if.source  chr_o
);
  import itoa_pkg::*;

  logic front_valid, front_ready;
  job_t front_job;
  logic queue_valid, queue_ready;
  job_t queue_job;

  // Request intake and classification.
  itoa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_value_i (req_i.value),
    .req_radix_i (req_i.radix_select),
    .req_min_i   (req_i.min_digits),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  // Job queue.
  itoa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_job_i   (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_job_o    (queue_job)
  );

  // Conversion and character output.
  itoa_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_ready_o (queue_ready),
    .job_i       (queue_job),
    .out_valid_o (chr_o.valid),
    .out_ready_i (chr_o.ready),
    .text_char_o (chr_o.text_char),
    .last_char_o (chr_o.last_char)
  );

endmodule

FILE: tb/radix_integer_to_ascii_core_test.sv
// Self-checking testbench for the radix integer to ASCII core.
`timescale 1ns / 1ps

module radix_integer_to_ascii_core_test;
  import itoa_pkg::*;

  localparam int          TEXT_MAX     = 48;    // maximum field width of the core
  localparam int          HOLD_CYCLES  = 600;   // long sink hold-off
  localparam int          STALL_LIMIT  = 4000;  // cycles without any handshake
  localparam int          TAIL_CYCLES  = 200;   // quiet time after the last character
  localparam int          RANDOM_COUNT = 480;
  localparam logic [7:0]  LETTER_A     = 8'h41;

  // One number to convert.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    radix_e             radix;
    logic [MIN_W-1:0]   min_digits;
  } number_req_t;

  // One character of text with its end-of-number flag.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // Ready patterns of the character sink.
  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_MOSTLY_OPEN,
    SINK_MOSTLY_SHUT,
    SINK_EVERY_THIRD
  } sink_mode_e;

  // Predicts the text of each accepted number and checks characters in order.
  class text_scoreboard;
    text_char_t  text_q[$];
    int unsigned mismatches;
    int unsigned numbers_seen;
    int unsigned chars_seen;
    int unsigned widest;
    int unsigned radix_hits [4];

    function void note_request(logic [VALUE_W-1:0] value, radix_e radix,
                               logic [MIN_W-1:0] min_digits);
      logic              neg;
      logic [31:0]       mag;
      logic [31:0]       rest;
      int unsigned       radix_base;
      int unsigned       ndig;
      int unsigned       width;
      int                pos;
      logic [3:0]        digits [TEXT_MAX];
      text_char_t        tc;
      neg = value[31];
      mag = neg ? (32'd0 - value) : value;
      case (radix)
        RADIX_BIN: radix_base = 2;
        RADIX_OCT: radix_base = 8;
        RADIX_DEC: radix_base = 10;
        default:   radix_base = 16;
      endcase
      // Natural length counts the sign; the width saturates at the core maximum.
      ndig = 0;
      rest = mag;
      do begin
        ndig++;
        rest = rest / radix_base;
      end while (rest != 0);
      width = ndig + neg;
      if (min_digits > width) width = min_digits;
      if (width > TEXT_MAX) width = TEXT_MAX;
      // Digits fill from the right, leading positions stay zero.
      for (int k = 0; k < TEXT_MAX; k++) digits[k] = 4'd0;
      pos  = width;
      rest = mag;
      while (rest != 0 && pos > 0) begin
        pos--;
        digits[pos] = 4'(rest % radix_base);
        rest = rest / radix_base;
      end
      for (int k = 0; k < width; k++) begin
        if (k == 0 && neg) begin
          tc.code = MINUS_CHAR;
        end else if (digits[k] < 4'd10) begin
          tc.code = ZERO_CHAR + 8'(digits[k]);
        end else begin
          tc.code = LETTER_A + 8'(digits[k]) - 8'd10;
        end
        tc.last = (k == width - 1);
        text_q.push_back(tc);
      end
      numbers_seen++;
      radix_hits[radix]++;
      if (width > widest) widest = width;
    endfunction

    function void report(string what, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      text_char_t want;
      chars_seen++;
      if (text_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character: expected none, actual %h last %b",
                 $time, code, last);
      end else begin
        want = text_q.pop_front();
        if (want.code !== code) report("text_char", want.code, code);
        if (want.last !== last) report("last_char", 8'(want.last), 8'(last));
      end
    endfunction

    function int unsigned outstanding();
      return text_q.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   hold_off_request = 1'b0;

  text_scoreboard sb = new();

  itoa_in_if  req_if ();
  itoa_out_if chr_if ();

  radix_integer_to_ascii_core #(
    .MAX_WIDTH(TEXT_MAX)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .chr_o (chr_if)
  );

  // Clock.
  always #1 clk = ~clk;

  // Offers one request and waits until the core takes it.
  task automatic send_request(input logic [VALUE_W-1:0] value, input radix_e radix,
                              input logic [MIN_W-1:0] min_digits);
    req_if.valid        <= 1'b1;
    req_if.value        <= value;
    req_if.radix_select <= radix;
    req_if.min_digits   <= min_digits;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(value, radix, min_digits);
  endtask

  // Lowers valid for a number of cycles.
  task automatic idle_gap(input int unsigned cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender until every expected character has arrived.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Random number with a spread of magnitudes, radixes and widths.
  function automatic number_req_t random_request();
    number_req_t req;
    logic [31:0] pow10;
    case ($urandom_range(0, 6))
      0: req.value = $urandom();
      1: req.value = $urandom_range(0, 20);
      2: req.value = 32'd0 - $urandom_range(1, 20);
      3: begin
        case ($urandom_range(0, 3))
          0: req.value = 32'h8000_0000;
          1: req.value = 32'h7FFF_FFFF;
          2: req.value = 32'h0000_0000;
          default: req.value = 32'hFFFF_FFFF;
        endcase
      end
      4: begin
        // Powers of two plus or minus one cross digit boundaries in the binary radixes.
        req.value = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
        if ($urandom_range(0, 1)) req.value = 32'd0 - req.value;
      end
      5: begin
        // Powers of ten and powers of ten minus one cross decimal digit boundaries.
        pow10 = 32'd1;
        repeat ($urandom_range(0, 9)) pow10 = pow10 * 32'd10;
        req.value = pow10 - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) req.value = 32'd0 - req.value;
      end
      default: begin
        req.value = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) req.value = 32'd0 - req.value;
      end
    endcase
    req.radix = radix_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: req.min_digits = MIN_W'($urandom_range(0, 4));
      6, 7:             req.min_digits = MIN_W'($urandom_range(5, 16));
      8:                req.min_digits = MIN_W'($urandom_range(17, 40));
      default:          req.min_digits = MIN_W'($urandom_range(41, 63));
    endcase
    return req;
  endfunction

  // Random requests in bursts with random gaps; some bursts follow with no gap.
  task automatic run_random(input int unsigned count);
    int unsigned burst_left;
    number_req_t req;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
      burst_left--;
      req = random_request();
      send_request(req.value, req.radix, req.min_digits);
    end
  endtask

  // Character sink: checks each character and drives ready on a changing pattern.
  initial begin : char_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned phase;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    chr_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (chr_if.valid && chr_if.ready) begin
        sb.check_char(chr_if.text_char, chr_if.last_char);
      end
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left        = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 4));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        chr_if.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:        chr_if.ready <= 1'b1;
          SINK_COIN:        chr_if.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY_OPEN: chr_if.ready <= ($urandom_range(0, 9) != 0);
          SINK_MOSTLY_SHUT: chr_if.ready <= ($urandom_range(0, 3) == 0);
          default:          chr_if.ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (chr_if.valid && chr_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("radix_integer_to_ascii_core_test: FAIL");
    $finish;
  end

  // Stimulus sequence.
  initial begin : stimulus
    number_req_t req;
    req_if.valid        <= 1'b0;
    req_if.value        <= '0;
    req_if.radix_select <= RADIX_BIN;
    req_if.min_digits   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero in every radix, value extremes, padding and saturation.
    send_request(32'h0000_0000, RADIX_BIN, 6'd0);
    send_request(32'h0000_0000, RADIX_OCT, 6'd0);
    send_request(32'h0000_0000, RADIX_DEC, 6'd0);
    send_request(32'h0000_0000, RADIX_HEX, 6'd0);
    send_request(32'h8000_0000, RADIX_BIN, 6'd0);
    send_request(32'h8000_0000, RADIX_OCT, 6'd0);
    send_request(32'h8000_0000, RADIX_DEC, 6'd0);
    send_request(32'h8000_0000, RADIX_HEX, 6'd0);
    send_request(32'h7FFF_FFFF, RADIX_BIN, 6'd0);
    send_request(32'h7FFF_FFFF, RADIX_DEC, 6'd0);
    send_request(32'hFFFF_FFFF, RADIX_DEC, 6'd0);
    send_request(32'hFFFF_FFFF, RADIX_HEX, 6'd0);
    send_request(32'h0000_0000, RADIX_DEC, 6'd48);
    send_request(32'h0000_0000, RADIX_HEX, 6'd63);
    send_request(32'h8000_0000, RADIX_BIN, 6'd63);
    send_request(32'h0000_00FF, RADIX_HEX, 6'd8);
    send_request(32'hFFFF_FF01, RADIX_OCT, 6'd10);
    send_request(32'd1_000_000_000, RADIX_DEC, 6'd0);
    send_request(32'd0 - 32'd999_999_999, RADIX_DEC, 6'd12);
    send_request(32'hFFFF_FFFB, RADIX_DEC, 6'd1);
    send_request(32'd10, RADIX_DEC, 6'd2);
    send_request(32'h00AB_CDEF, RADIX_HEX, 6'd33);
    send_request(32'h7FFF_FFFF, RADIX_OCT, 6'd47);
    wait_drained();

    run_random(RANDOM_COUNT / 2);

    // Long sink hold-off while requests keep coming, so the core backs up.
    wait_drained();
    hold_off_request = 1'b1;
    repeat (24) begin
      req = random_request();
      send_request(req.value, req.radix, req.min_digits);
    end

    run_random(RANDOM_COUNT / 2);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display({"Converted %0d numbers (binary %0d, octal %0d, decimal %0d, hex %0d)",
              " into %0d characters."},
             sb.numbers_seen, sb.radix_hits[RADIX_BIN], sb.radix_hits[RADIX_OCT],
             sb.radix_hits[RADIX_DEC], sb.radix_hits[RADIX_HEX], sb.chars_seen);
    $display({"Widths reached %0d; value extremes, padding, saturation and a long",
              " sink stall were exercised."},
             sb.widest);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("radix_integer_to_ascii_core_test: PASS");
    end else begin
      $display("radix_integer_to_ascii_core_test: FAIL");
    end
    $finish;
  end

endmodule
